[sv/zbap_pkg.sv]
// Package for the elevation-point depth-buffer block.
// Shared types and constants; no dependencies.
package zbap_pkg;
  localparam int MaxImageWidth  = 256;
  localparam int MaxImageHeight = 256;
  localparam int XW = $clog2(MaxImageWidth);
  localparam int YW = $clog2(MaxImageHeight);
  localparam int AW = XW + YW;
  localparam int DEPTH = MaxImageWidth * MaxImageHeight;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_U_CR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_U_HO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V_CR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_HO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_H    = 3'd5;

  localparam logic signed [31:0] HEIGHT_SUBST = 32'sh0014_0000;
  localparam logic signed [31:0] DEPTH_CLEAR  = -32'sd6553600;

  typedef struct packed {
    logic        mode;
    logic [11:0] point_col;
    logic [11:0] point_row;
    logic signed [31:0] point_height;
  } in_item_t;

  typedef struct packed {
    logic        visible;
    logic signed [31:0] proj_u;
    logic signed [31:0] proj_v;
  } out_item_t;

  // Queued work: classified point for the depth stage
  typedef struct packed {
    logic        mode;
    logic [AW-1:0] addr;
    logic signed [31:0] hgt;
    logic signed [31:0] qu;
    logic signed [31:0] qv;
  } job_t;
endpackage

[sv/zbap_if.sv]
// Valid/ready channel interface carrying one item per beat.
// Depends on nothing; payload type set per instance.
interface zbap_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/zbuffer_affine_projection_visibility.sv]
// Top level of the elevation-point depth-buffer block.
// Depends on zbap_pkg, zbap_if, zbap_front, zbap_back.
//  channel | dir | beat contents
//  in_     | in  | mode, point_col, point_row, point_height
//  out_    | out | visible, proj_u, proj_v (mode 1 only)
//  cfg_    | in  | register index and 64-bit data, write only
// Front: four-stage projection pipeline, one point per cycle when not stalled.
// Back: takes one point at a time and finishes it before the next, paced by
// the depth memory read-then-write port; front stalls when back is busy.
// After reset a clearing pass over all 65536 depth entries runs before any point.
// Output has one result register; it stalls the back end when held.
module zbuffer_affine_projection_visibility (
  input  logic clk,
  input  logic rst_n,
  zbap_if.sink   in_ch,
  zbap_if.source out_ch,
  input  logic cfg_we,
  input  logic [zbap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zbap_pkg::CFG_DATA_W-1:0] cfg_data
);
  import zbap_pkg::*;

  logic [63:0] ucr_r, uho_r, vcr_r, vho_r;
  logic [8:0] w_r, h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucr_r <= '0; uho_r <= '0; vcr_r <= '0; vho_r <= '0;
      w_r <= 9'd256; h_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_U_CR: ucr_r <= cfg_data;
        REG_U_HO: uho_r <= cfg_data;
        REG_V_CR: vcr_r <= cfg_data;
        REG_V_HO: vho_r <= cfg_data;
        REG_W:    w_r <= cfg_data[8:0];
        REG_H:    h_r <= cfg_data[8:0];
        default:  ;
      endcase
    end
  end

  logic jv, jr, busy, fr;
  job_t jb;

  // Front stalls while back is not taking jobs
  zbap_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid && !busy), .in_ready(fr), .in_data(in_ch.data),
    .coef_u_cr(ucr_r), .coef_u_ho(uho_r), .coef_v_cr(vcr_r), .coef_v_ho(vho_r),
    .img_w(w_r), .img_h(h_r),
    .job_valid(jv), .job_ready(jr), .job(jb)
  );
  assign in_ch.ready = fr && !busy;

  zbap_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(jv), .job_ready(jr), .job(jb),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .busy_clear(busy)
  );

  // No point taken during the clearing pass
  a_no_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("input taken during clear");
  // Hidden results carry zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.visible |-> out_ch.data.proj_u == 0 &&
    out_ch.data.proj_v == 0) else $error("hidden result not zeroed");
  // Clear pass, once ended, does not restart before the next reset
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy) else $error("clear pass restarted");
endmodule

[sv/zbap_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module zbap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/zbap_front.sv]
// Front end: projection pipeline producing depth-store jobs.
// Depends on zbap_pkg.
module zbap_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  zbap_pkg::in_item_t in_data,
  input  logic [63:0] coef_u_cr,
  input  logic [63:0] coef_u_ho,
  input  logic [63:0] coef_v_cr,
  input  logic [63:0] coef_v_ho,
  input  logic [8:0]  img_w,
  input  logic [8:0]  img_h,
  output logic job_valid,
  input  logic job_ready,
  output zbap_pkg::job_t job
);
  import zbap_pkg::*;

  // Stage 1: operand capture, height substitution
  logic s1_r, s2_r, s3_r, s4_r;
  logic s1_mode_r, s2_mode_r, s3_mode_r;
  logic signed [31:0] s1_h_r, s2_h_r, s3_h_r;
  logic [11:0] s1_c_r, s1_o_r;
  logic stall;
  assign stall = s4_r && !job_ready;
  assign in_ready = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0; s2_r <= 1'b0; s3_r <= 1'b0; s4_r <= 1'b0;
    end else if (!stall) begin
      s1_r <= in_valid; s2_r <= s1_r; s3_r <= s2_r; s4_r <= s3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_mode_r <= in_data.mode;
      s1_c_r <= in_data.point_col;
      s1_o_r <= in_data.point_row;
      s1_h_r <= in_data.point_height[31] ? HEIGHT_SUBST : in_data.point_height;
    end
  end

  // Stage 2: products, one register after the multipliers
  logic signed [63:0] pu_a_r, pu_b_r, pu_c_r, pv_a_r, pv_b_r, pv_c_r;
  logic signed [31:0] du_r, dv_r;
  always_ff @(posedge clk) begin
    if (!stall) begin
      pu_a_r <= 64'(signed'(coef_u_cr[63:32]) * signed'({1'b0, s1_c_r}));
      pu_b_r <= 64'(signed'(coef_u_cr[31:0])  * signed'({1'b0, s1_o_r}));
      pu_c_r <= 64'(signed'(coef_u_ho[63:32]) * s1_h_r);
      pv_a_r <= 64'(signed'(coef_v_cr[63:32]) * signed'({1'b0, s1_c_r}));
      pv_b_r <= 64'(signed'(coef_v_cr[31:0])  * signed'({1'b0, s1_o_r}));
      pv_c_r <= 64'(signed'(coef_v_ho[63:32]) * s1_h_r);
      du_r <= coef_u_ho[31:0];
      dv_r <= coef_v_ho[31:0];
      s2_mode_r <= s1_mode_r;
      s2_h_r <= s1_h_r;
    end
  end

  // Stage 3: sums in Q32.32, registered
  logic signed [63:0] su_r, sv_r;
  always_ff @(posedge clk) begin
    if (!stall) begin
      su_r <= ((pu_a_r + pu_b_r + 64'(du_r)) <<< 16) + pu_c_r;
      sv_r <= ((pv_a_r + pv_b_r + 64'(dv_r)) <<< 16) + pv_c_r;
      s3_mode_r <= s2_mode_r;
      s3_h_r <= s2_h_r;
    end
  end

  function automatic logic signed [47:0] rnd16(input logic signed [63:0] s);
    logic [63:0] m;
    m = s[63] ? (64'd0 - s) : s;
    m = (m + 64'h8000) >> 16;
    return s[63] ? -48'(m) : 48'(m);
  endfunction

  function automatic logic signed [31:0] rnd32(input logic signed [63:0] s);
    logic [63:0] m;
    m = s[63] ? (64'd0 - s) : s;
    m = (m + 64'h8000_0000) >> 32;
    return s[63] ? -32'(m) : 32'(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [8:0] eff(input logic [8:0] r, input logic [8:0] mx);
    if (r == 9'd0) return 9'd1;
    if (r > mx) return mx;
    return r;
  endfunction

  // Stage 4 combinational: rounding, clamp, address
  logic [8:0] w, h;
  logic signed [31:0] iu, iv;
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  assign w = eff(img_w, 9'(MaxImageWidth));
  assign h = eff(img_h, 9'(MaxImageHeight));
  assign iu = rnd32(su_r);
  assign iv = rnd32(sv_r);
  always_comb begin
    if (iu < 0) px = '0;
    else if (iu > 32'(w) - 1) px = XW'(w - 9'd1);
    else px = XW'(iu);
    if (iv < 0) py = '0;
    else if (iv > 32'(h) - 1) py = YW'(h - 9'd1);
    else py = YW'(iv);
  end

  job_t job_r;
  always_ff @(posedge clk) begin
    if (!stall) begin
      job_r.mode <= s3_mode_r;
      job_r.addr <= AW'(py * w + 17'(px));
      job_r.hgt <= s3_h_r;
      job_r.qu <= sat32(rnd16(su_r));
      job_r.qv <= sat32(rnd16(sv_r));
    end
  end
  assign job = job_r;
  assign job_valid = s4_r;
endmodule

[sv/zbap_back.sv]
// Back end: clearing pass, depth read-modify-write, result register.
// Depends on zbap_pkg and zbap_ram.
module zbap_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  zbap_pkg::job_t job,
  output logic out_valid,
  input  logic out_ready,
  output zbap_pkg::out_item_t out_data,
  output logic busy_clear
);
  import zbap_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [AW-1:0] clr_r;
  job_t cur_r;
  logic ov_r;
  out_item_t od_r;
  logic we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata, rdata;

  zbap_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(job.addr), .rdata(rdata)
  );

  assign busy_clear = (st_r == ST_CLEAR);
  assign job_ready = (st_r == ST_IDLE);
  logic hit;
  assign hit = (signed'(rdata) == cur_r.hgt);

  // Write: clear sweep or fill update
  always_comb begin
    we = 1'b0; waddr = cur_r.addr; wdata = cur_r.hgt;
    case (st_r)
      ST_CLEAR: begin we = 1'b1; waddr = clr_r; wdata = DEPTH_CLEAR; end
      ST_READ:  we = !cur_r.mode && (signed'(rdata) < cur_r.hgt);
      default:  we = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (&clr_r) st_nxt = ST_IDLE;
      ST_IDLE:  if (job_valid) st_nxt = ST_READ;
      ST_READ:  st_nxt = cur_r.mode ? ST_DONE : ST_IDLE;
      ST_DONE:  if (!ov_r || out_ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (st_r == ST_DONE && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // Hold the job; latch the result once the output slot frees
  logic hit_r;
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && job_valid) cur_r <= job;
    if (st_r == ST_READ) hit_r <= hit;
    if (st_r == ST_DONE && (!ov_r || out_ready)) begin
      od_r.visible <= hit_r;
      od_r.proj_u <= hit_r ? cur_r.qu : '0;
      od_r.proj_v <= hit_r ? cur_r.qv : '0;
    end
  end

  assign out_valid = ov_r;
  assign out_data = od_r;
endmodule
